/* hw/rtl/mlod_pkg.sv */
// Shared types, constants and functions for the multilevel ordered dither.
// No dependencies; imported by every module of the block.
package mlod_pkg;

    localparam int COMP_BITS  = 8;
    localparam int LEVEL_BITS = 9;
    localparam int IDX_BITS   = 2;
    localparam int QUO_BITS   = 8;
    localparam int CH_DEPTH   = 7 + QUO_BITS;
    localparam int PIPE_DEPTH = 1 + CH_DEPTH;
    localparam int COORD_BITS_DEF = 12;

    localparam logic [IDX_BITS-1:0] REG_LEVELS_RED   = 2'd0;
    localparam logic [IDX_BITS-1:0] REG_LEVELS_GREEN = 2'd1;
    localparam logic [IDX_BITS-1:0] REG_LEVELS_BLUE  = 2'd2;

    typedef enum logic [2:0] {SZ_2, SZ_3, SZ_4, SZ_6, SZ_8, SZ_12, SZ_16} size_t;

    typedef struct packed {
        logic [1:0] rx3;
        logic [1:0] ry3;
        logic [3:0] xlo;
        logic [3:0] ylo;
    } coord_t;

    localparam logic [1:0] BASE2 [2][2] = '{'{2'd0, 2'd2}, '{2'd3, 2'd1}};
    localparam logic [3:0] BASE3 [3][3] = '{'{4'd6, 4'd8, 4'd4},
                                            '{4'd1, 4'd0, 4'd3},
                                            '{4'd5, 4'd2, 4'd7}};

    function automatic int size_of(size_t sel);
        int n;
        case (sel)
            SZ_2:    n = 2;
            SZ_3:    n = 3;
            SZ_4:    n = 4;
            SZ_6:    n = 6;
            SZ_8:    n = 8;
            SZ_12:   n = 12;
            default: n = 16;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] thr_fn(size_t sel, logic [3:0] i, logic [3:0] j);
        int n;
        int h;
        int ii;
        int jj;
        int val;
        int sh;
        n   = size_of(sel);
        ii  = int'(i);
        jj  = int'(j);
        val = 0;
        sh  = 0;
        for (int k = 0; k < 3; k++)
        begin
            if (n > 3)
            begin
                h   = n >> 1;
                val = val + (int'(BASE2[ii >= h][jj >= h]) << sh);
                sh  = sh + 2;
                ii  = (ii >= h) ? ii - h : ii;
                jj  = (jj >= h) ? jj - h : jj;
                n   = h;
            end
        end
        if (n == 3)
            val = val + (int'(BASE3[ii[1:0]][jj[1:0]]) << sh);
        else
            val = val + (int'(BASE2[ii[0]][jj[0]]) << sh);
        return val[7:0];
    endfunction

    // residue mod 12 from residues mod 3 and mod 4
    function automatic logic [3:0] crt12(logic [1:0] r3, logic [1:0] r4);
        logic [3:0] res;
        res = '0;
        for (int t = 0; t < 12; t++)
        begin
            if ((t % 3) == int'(r3) && (t % 4) == int'(r4))
                res = 4'(t);
        end
        return res;
    endfunction

endpackage

/* hw/rtl/mlod_div_stage.sv */
// One restoring-division step: one quotient bit per register stage.
// Depends on mlod_pkg.
module mlod_div_stage #(
    parameter int BIT = 0
) (
    input  logic        clk,
    input  logic        en,
    input  logic [8:0]  divisor,
    input  logic [16:0] rem_in,
    input  logic [mlod_pkg::QUO_BITS-1:0] quo_in,
    output logic [16:0] rem_out,
    output logic [mlod_pkg::QUO_BITS-1:0] quo_out
);
    import mlod_pkg::*;

    logic [16:0] dsh;
    logic [16:0] rem_reg, rem_next;
    logic [QUO_BITS-1:0] quo_reg, quo_next;

    always_comb
    begin
        dsh      = 17'(divisor) << BIT;
        rem_next = rem_in;
        quo_next = quo_in;
        if (rem_in >= dsh)
        begin
            rem_next      = rem_in - dsh;
            quo_next[BIT] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign rem_out = rem_reg;
    assign quo_out = quo_reg;
endmodule

/* hw/rtl/mlod_channel.sv */
// Dither pipeline for one colour channel: scale, level split, threshold, rescale.
// Depends on mlod_pkg and mlod_div_stage.
module mlod_channel (
    input  logic                  clk,
    input  logic                  en,
    input  logic [mlod_pkg::LEVEL_BITS-1:0] kreg,
    input  logic [mlod_pkg::COMP_BITS-1:0]  comp_in,
    input  mlod_pkg::coord_t      coord,
    output logic [mlod_pkg::COMP_BITS-1:0]  comp_out
);
    import mlod_pkg::*;

    // the user must keep the level count static while items are in flight; the block does not enforce it
    logic [7:0]  km1;
    size_t       sel;
    logic [11:0] p_wide;
    logic [9:0]  p;
    logic [3:0]  s;
    logic        is3;
    logic [9:0]  vmask;

    always_comb
    begin
        if (kreg < 9'd2)
            km1 = 8'd1;
        else if (kreg > 9'd256)
            km1 = 8'd255;
        else
            km1 = 8'(kreg - 9'd1);

        if (km1 >= 8'd64)      sel = SZ_2;
        else if (km1 >= 8'd29) sel = SZ_3;
        else if (km1 >= 8'd16) sel = SZ_4;
        else if (km1 >= 8'd8)  sel = SZ_6;
        else if (km1 >= 8'd4)  sel = SZ_8;
        else if (km1 >= 8'd2)  sel = SZ_12;
        else                   sel = SZ_16;

        case (sel)
            SZ_2:    begin p_wide = 12'(km1) << 2; s = 4'd2; is3 = 1'b0; end
            SZ_3:    begin p_wide = (12'(km1) << 3) + 12'(km1); s = 4'd0; is3 = 1'b1; end
            SZ_4:    begin p_wide = 12'(km1) << 4; s = 4'd4; is3 = 1'b0; end
            SZ_6:    begin p_wide = ((12'(km1) << 3) + 12'(km1)) << 2; s = 4'd2; is3 = 1'b1; end
            SZ_8:    begin p_wide = 12'(km1) << 6; s = 4'd6; is3 = 1'b0; end
            SZ_12:   begin p_wide = ((12'(km1) << 3) + 12'(km1)) << 4; s = 4'd4; is3 = 1'b1; end
            default: begin p_wide = 12'(km1) << 8; s = 4'd8; is3 = 1'b0; end
        endcase
        p     = p_wide[9:0];
        vmask = (10'd1 << s) - 10'd1;
    end

    // stage 1: residues
    logic [3:0] t12x, t12y, ix, iy;
    logic [3:0] ix_reg, iy_reg;
    logic [7:0] c1_reg;

    always_comb
    begin
        t12x = crt12(coord.rx3, coord.xlo[1:0]);
        t12y = crt12(coord.ry3, coord.ylo[1:0]);
        case (sel)
            SZ_2:    begin ix = {3'd0, coord.xlo[0]}; iy = {3'd0, coord.ylo[0]}; end
            SZ_3:    begin ix = {2'd0, coord.rx3}; iy = {2'd0, coord.ry3}; end
            SZ_4:    begin ix = {2'd0, coord.xlo[1:0]}; iy = {2'd0, coord.ylo[1:0]}; end
            SZ_6:
            begin
                ix = (t12x >= 4'd6) ? t12x - 4'd6 : t12x;
                iy = (t12y >= 4'd6) ? t12y - 4'd6 : t12y;
            end
            SZ_8:    begin ix = {1'b0, coord.xlo[2:0]}; iy = {1'b0, coord.ylo[2:0]}; end
            SZ_12:   begin ix = t12x; iy = t12y; end
            default: begin ix = coord.xlo; iy = coord.ylo; end
        endcase
    end

    // stage 2: threshold and scaled product
    logic [17:0] b2_reg;
    logic [7:0]  thr2_reg;

    // stage 3..7
    logic [17:0] b3_reg;
    logic [9:0]  q3_reg;
    logic [7:0]  thr3_reg, thr4_reg, thr5_reg;
    logic [26:0] prod3;
    logic [17:0] r4;
    logic [9:0]  v4_reg;
    logic [18:0] prod5;
    logic [9:0]  w5_reg;
    logic [6:0]  q5_reg;
    logic [7:0]  vlo5_reg;
    logic [9:0]  w5;
    logic [9:0]  r6;
    logic [7:0]  lev6, rem6;
    logic [7:0]  lvl6_reg;
    logic [16:0] dvd7_reg;

    assign prod3 = 27'(b2_reg) * 27'd257;
    assign r4    = b3_reg - ((18'(q3_reg) << 8) - 18'(q3_reg));
    assign w5    = v4_reg >> s;
    assign prod5 = 19'(w5) * 19'd455;

    always_comb
    begin
        r6   = w5_reg - ((10'(q5_reg) << 3) + 10'(q5_reg));
        lev6 = 8'(q5_reg);
        if (r6 >= 10'd9)
        begin
            r6   = r6 - 10'd9;
            lev6 = lev6 + 8'd1;
        end
        if (is3)
            rem6 = 8'(r6 << s) | vlo5_reg;
        else
        begin
            lev6 = w5_reg[7:0];
            rem6 = vlo5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ix_reg   <= ix;
            iy_reg   <= iy;
            c1_reg   <= comp_in;
            thr2_reg <= thr_fn(sel, ix_reg, iy_reg);
            b2_reg   <= (18'(c1_reg) * 18'(p)) + 18'd127;
            b3_reg   <= b2_reg;
            q3_reg   <= prod3[25:16];
            thr3_reg <= thr2_reg;
            v4_reg   <= (r4 >= 18'd255) ? q3_reg + 10'd1 : q3_reg;
            thr4_reg <= thr3_reg;
            w5_reg   <= w5;
            q5_reg   <= prod5[18:12];
            vlo5_reg <= 8'(v4_reg & vmask);
            thr5_reg <= thr4_reg;
            lvl6_reg <= (rem6 > thr5_reg) ? lev6 + 8'd1 : lev6;
            dvd7_reg <= (17'(lvl6_reg) << 9) - (17'(lvl6_reg) << 1) + 17'(km1);
        end
    end

    // stages 8 onward: quotient bits, most significant first
    logic [16:0]         rem_c [QUO_BITS+1];
    logic [QUO_BITS-1:0] quo_c [QUO_BITS+1];

    assign rem_c[0] = dvd7_reg;
    assign quo_c[0] = '0;

    for (genvar g = 0; g < QUO_BITS; g++)
    begin : g_div
        mlod_div_stage #(.BIT(QUO_BITS - 1 - g)) u_stage (
            .clk     (clk),
            .en      (en),
            .divisor ({km1, 1'b0}),
            .rem_in  (rem_c[g]),
            .quo_in  (quo_c[g]),
            .rem_out (rem_c[g+1]),
            .quo_out (quo_c[g+1])
        );
    end

    assign comp_out = quo_c[QUO_BITS];
endmodule

/* hw/rtl/multilevel_ordered_dither_top.sv */
// Top level of the multilevel ordered dither: config registers, input stage, valid chain.
// Depends on mlod_pkg and mlod_channel.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_stall  | red_in, green_in, blue_in, column, line
//  out     | out_valid / out_stall| red_out, green_out, blue_out
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data (always ready)
//
// One pixel per clock while out_stall does not freeze the pipeline; its PIPE_DEPTH stages are the input stage,
// the scale multipliers and the eight-step rescale divider, one quotient bit per stage.
// Reset clears the valid chain and sets every level count to 2.
// out_stall with a result waiting freezes the whole pipeline; in_stall follows it.
module multilevel_ordered_dither_top #(
    parameter int COORD_BITS = mlod_pkg::COORD_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [7:0]              red_in,
    input  logic [7:0]              green_in,
    input  logic [7:0]              blue_in,
    input  logic [COORD_BITS-1:0]   column,
    input  logic [COORD_BITS-1:0]   line,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [7:0]              red_out,
    output logic [7:0]              green_out,
    output logic [7:0]              blue_out,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [mlod_pkg::IDX_BITS-1:0]   cfg_index,
    input  logic [mlod_pkg::LEVEL_BITS-1:0] cfg_data
);
    import mlod_pkg::*;

    function automatic logic [1:0] mod3(logic [COORD_BITS-1:0] x);
        logic [1:0] acc;
        logic [2:0] sum;
        acc = 2'd0;
        for (int k = 0; k < COORD_BITS; k++)
        begin
            if (x[k])
            begin
                sum = {1'b0, acc} + ((k % 2 == 1) ? 3'd2 : 3'd1);
                acc = (sum >= 3'd3) ? 2'(sum - 3'd3) : sum[1:0];
            end
        end
        return acc;
    endfunction

    logic [LEVEL_BITS-1:0] lvl_red_reg, lvl_green_reg, lvl_blue_reg;
    logic [PIPE_DEPTH-1:0] vld_reg, vld_next;
    logic                  en;
    logic [7:0]            r0_reg, g0_reg, b0_reg;
    coord_t                crd_reg;

    assign cfg_ready = 1'b1;
    assign en        = !(vld_reg[PIPE_DEPTH-1] && out_stall);
    assign in_stall  = !en;
    assign out_valid = vld_reg[PIPE_DEPTH-1];
    assign vld_next  = {vld_reg[PIPE_DEPTH-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lvl_red_reg   <= 9'd2;
            lvl_green_reg <= 9'd2;
            lvl_blue_reg  <= 9'd2;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_LEVELS_RED:   lvl_red_reg   <= cfg_data;
                REG_LEVELS_GREEN: lvl_green_reg <= cfg_data;
                REG_LEVELS_BLUE:  lvl_blue_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r0_reg      <= red_in;
            g0_reg      <= green_in;
            b0_reg      <= blue_in;
            crd_reg.rx3 <= mod3(column);
            crd_reg.ry3 <= mod3(line);
            crd_reg.xlo <= column[3:0];
            crd_reg.ylo <= line[3:0];
        end
    end

    mlod_channel u_red (
        .clk      (clk),
        .en       (en),
        .kreg     (lvl_red_reg),
        .comp_in  (r0_reg),
        .coord    (crd_reg),
        .comp_out (red_out)
    );

    mlod_channel u_green (
        .clk      (clk),
        .en       (en),
        .kreg     (lvl_green_reg),
        .comp_in  (g0_reg),
        .coord    (crd_reg),
        .comp_out (green_out)
    );

    mlod_channel u_blue (
        .clk      (clk),
        .en       (en),
        .kreg     (lvl_blue_reg),
        .comp_in  (b0_reg),
        .coord    (crd_reg),
        .comp_out (blue_out)
    );
endmodule

/* dv/multilevel_ordered_dither_top_tb.sv */
// Self-checking testbench for multilevel_ordered_dither_top: random and directed pixels
// under several level-count settings, with its own per-channel dither predictor.
// Depends on mlod_pkg and the RTL of the block.
module multilevel_ordered_dither_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mlod_pkg::*;

    localparam int CB = COORD_BITS_DEF;

    typedef struct {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } pixel_t;

    class dither_scoreboard;
        pixel_t pending[$];
        int     mismatches;
        int     checked;
        logic [8:0] levels[3];

        function new();
            mismatches = 0;
            checked = 0;
            for (int c = 0; c < 3; c++)
                levels[c] = 9'd2;
        endfunction

        function int pick_size(int km1);
            int sz[7] = '{2, 3, 4, 6, 8, 12, 16};
            for (int t = 0; t < 7; t++)
                if (sz[t] * sz[t] * km1 >= 256)
                    return sz[t];
            return 16;
        endfunction

        function int bayer(int n, int i, int j);
            int val;
            int mult;
            int h;
            int b2[2][2] = '{'{0, 2}, '{3, 1}};
            int b3[3][3] = '{'{6, 8, 4}, '{1, 0, 3}, '{5, 2, 7}};
            val = 0;
            mult = 1;
            while (n > 3)
            begin
                h = n / 2;
                val += mult * b2[(i / h) % 2][(j / h) % 2];
                mult *= 4;
                i = i % h;
                j = j % h;
                n = h;
            end
            if (n == 3)
                val += mult * b3[i % 3][j % 3];
            else
                val += mult * b2[i % 2][j % 2];
            return val;
        endfunction

        function logic [7:0] quantise(logic [8:0] kreg, logic [7:0] c, int x, int y);
            int km1;
            int n;
            int nn;
            longint v;
            longint lvl;
            longint o;
            km1 = (kreg < 2) ? 1 : ((kreg > 256) ? 255 : int'(kreg) - 1);
            n = pick_size(km1);
            nn = n * n;
            v = (2 * longint'(c) * km1 * nn + 255) / 510;
            lvl = v / nn;
            if ((v % nn) > bayer(n, x % n, y % n))
                lvl++;
            o = (510 * lvl + km1) / (2 * km1);
            if (o > 255)
                o = 255;
            return o[7:0];
        endfunction

        function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                 logic [CB-1:0] x, logic [CB-1:0] y);
            pixel_t p;
            p.r = quantise(levels[0], r, int'(x), int'(y));
            p.g = quantise(levels[1], g, int'(x), int'(y));
            p.b = quantise(levels[2], b, int'(x), int'(y));
            pending.push_back(p);
        endfunction

        function void check_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            pixel_t p;
            checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %0d/%0d/%0d", r, g, b);
                return;
            end
            p = pending.pop_front();
            if (p.r !== r || p.g !== g || p.b !== b)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                             p.r, p.g, p.b, r, g, b);
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    logic [7:0] red_in = 0, green_in = 0, blue_in = 0;
    logic [CB-1:0] column = 0, line = 0;
    logic out_valid;
    logic out_stall = 0;
    logic [7:0] red_out, green_out, blue_out;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [IDX_BITS-1:0] cfg_index = 0;
    logic [LEVEL_BITS-1:0] cfg_data = 0;

    dither_scoreboard sb = new();
    int send_idle = 0;
    int recv_idle = 0;
    bit hold_off = 0;
    int quiet = 0;
    int sent = 0;

    always #1 clk = ~clk;

    multilevel_ordered_dither_top DUT (.*);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_pixel(red_out, green_out, blue_out);
            if ((out_valid && !out_stall) || (in_valid && !in_stall) || (cfg_valid && cfg_ready))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet > 20000)
            begin
                $display("watchdog expired");
                $display("end of test: mismatches");
                $finish;
            end
            out_stall <= hold_off || ($urandom_range(99) < recv_idle);
        end
    end

    task automatic write_level(logic [IDX_BITS-1:0] idx, logic [8:0] k);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= k;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_LEVELS_RED || idx == REG_LEVELS_GREEN || idx == REG_LEVELS_BLUE)
            sb.levels[idx] = k;
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                              logic [CB-1:0] x, logic [CB-1:0] y);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        red_in <= r;
        green_in <= g;
        blue_in <= b;
        column <= x;
        line <= y;
        do @(posedge clk); while (in_stall);
        sb.note_pixel(r, g, b, x, y);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 4) @(posedge clk);
    endtask

    task automatic random_pixels(int count);
        for (int i = 0; i < count; i++)
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom),
                       CB'($urandom), CB'($urandom));
    endtask

    task automatic set_levels(logic [8:0] r, logic [8:0] g, logic [8:0] b);
        write_level(REG_LEVELS_RED, r);
        write_level(REG_LEVELS_GREEN, g);
        write_level(REG_LEVELS_BLUE, b);
    endtask

    function automatic logic [8:0] rand_level();
        case ($urandom_range(3))
            0: return 9'($urandom_range(2, 17));
            1: return 9'($urandom_range(0, 511));
            default: return 9'($urandom_range(2, 256));
        endcase
    endfunction

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, corners of the matrix, saturated level counts
        send_pixel(8'd0, 8'd255, 8'd128, '0, '0);
        send_pixel(8'd255, 8'd0, 8'd127, '1, '1);
        send_pixel(8'd1, 8'd254, 8'd64, 12'd1, 12'd2);
        drain();
        set_levels(9'd256, 9'd0, 9'd511);
        send_pixel(8'd255, 8'd255, 8'd255, '1, '0);
        send_pixel(8'd0, 8'd1, 8'd200, '0, '1);
        send_pixel(8'd170, 8'd85, 8'd3, 12'hAAA, 12'h555);
        drain();
        set_levels(9'd3, 9'd5, 9'd257);
        for (int i = 0; i < 12; i++)
            send_pixel(8'(i * 23), 8'(255 - i * 21), 8'(i * 11), 12'(i), 12'(11 - i));
        drain();
        set_levels(9'd1, 9'd17, 9'd255);
        send_pixel(8'd128, 8'd128, 8'd128, 12'd15, 12'd15);
        send_pixel(8'd255, 8'd200, 8'd254, 12'd3, 12'd7);
        drain();
        write_level(2'd3, 9'h1FF);
        send_pixel(8'd99, 8'd99, 8'd99, 12'd5, 12'd6);

        // receiver holds off while the sender keeps offering
        fork
            begin
                hold_off = 1;
                repeat (60) @(posedge clk);
                hold_off = 0;
            end
            random_pixels(40);
        join
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle = (phase == 0) ? 19 : (phase == 1) ? 47 : 0;
            recv_idle = (phase == 0) ? 47 : (phase == 1) ? 19 : 0;
            for (int s = 0; s < 4; s++)
            begin
                set_levels(rand_level(), rand_level(), rand_level());
                random_pixels(130);
                drain();
            end
        end
        send_idle = 0;
        recv_idle = 0;
        drain();

        $display("covered %0d pixels, %0d results checked, level counts 0..511 incl. extremes",
                 sent, sb.checked);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

/* files.f */
hw/rtl/mlod_pkg.sv
hw/rtl/mlod_div_stage.sv
hw/rtl/mlod_channel.sv
hw/rtl/multilevel_ordered_dither_top.sv
dv/multilevel_ordered_dither_top_tb.sv
